// ===== sv/mstw_pkg.sv =====
// Shared types and codes of the sample table walker.
// Request and result structs, operation, status and register codes.
// No dependencies.
package mstw_pkg;

	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] slot;
		logic [63:0] first_value;
		logic [31:0] second_value;
	} req_t;

	typedef struct packed {
		logic [63:0] sample_offset;
		logic [31:0] sample_size;
		logic [63:0] decode_time;
		logic [1:0]  status;
	} res_t;

	localparam logic [2:0] OP_LOAD_RUN   = 3'd0;
	localparam logic [2:0] OP_LOAD_CHUNK = 3'd1;
	localparam logic [2:0] OP_LOAD_SIZE  = 3'd2;
	localparam logic [2:0] OP_LOAD_TIME  = 3'd3;
	localparam logic [2:0] OP_REQUEST    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_PAST_END = 2'd1;
	localparam logic [1:0] ST_NO_RUNS  = 2'd2;

	localparam logic [1:0] REG_RUN_ENTRIES  = 2'd0;
	localparam logic [1:0] REG_TIME_ENTRIES = 2'd1;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

	localparam int DIV_W = 32;

endpackage

// ===== sv/mstw_ram.sv =====
// Single-port-write, single-port-read table memory with registered read.
// No dependencies.
module mstw_ram #(
	parameter int W = 64,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/mstw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mstw_pkg.
module mstw_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mstw_pkg::DIV_W-1:0] dividend,
	input  logic [mstw_pkg::DIV_W-1:0] divisor,
	output logic                     done,
	output logic [mstw_pkg::DIV_W-1:0] quotient,
	output logic [mstw_pkg::DIV_W-1:0] remainder
);
	import mstw_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== sv/mp4_sample_table_walker_unit.sv =====
// Sample table walker top: four table memories, run/time cursors, sequencer,
// result register. Depends on mstw_pkg, mstw_ram, mstw_div.
// A request skips run entries, divides to find the chunk, adds the sizes of the
// earlier samples of the chunk and reads time entries; errors skip these steps.
// One request at a time, input held while a result waits. Reset clears cursors,
// registers and result.
module mp4_sample_table_walker_unit #(
	parameter int RUN_DEPTH = 256,
	parameter int CHUNK_DEPTH = 4096,
	parameter int SAMPLE_DEPTH = 16384,
	parameter int TIME_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mstw_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mstw_pkg::res_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [14:0]    cfg_data
);
	import mstw_pkg::*;

	localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int TAW = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;

	typedef enum logic [16:0] {
		S_IDLE    = 17'd1 << 0,
		S_CHECK   = 17'd1 << 1,
		S_RUN_A   = 17'd1 << 2,
		S_RUN_B   = 17'd1 << 3,
		S_RUN_MUL = 17'd1 << 4,
		S_RUN_CMP = 17'd1 << 5,
		S_DIV_SET = 17'd1 << 6,
		S_DIV     = 17'd1 << 7,
		S_OFS     = 17'd1 << 8,
		S_OFS_D   = 17'd1 << 9,
		S_SUM     = 17'd1 << 10,
		S_SIZE    = 17'd1 << 11,
		S_SIZE_D  = 17'd1 << 12,
		S_TIME    = 17'd1 << 13,
		S_TIME_D  = 17'd1 << 14,
		S_FIN     = 17'd1 << 15,
		S_OUT     = 17'd1 << 16
	} state_t;

	state_t state_q;

	logic [8:0]  run_entries_q;
	logic [8:0]  time_entries_q;
	logic [14:0] sample_count_q;

	logic [14:0] next_sample_q;
	logic [8:0]  run_cursor_q;
	logic [31:0] run_first_q;
	logic [8:0]  time_cursor_q;
	logic [31:0] time_first_q;
	logic [63:0] last_time_q;

	logic [63:0] cur_q;
	logic [31:0] diff_q;
	logic [31:0] span_q;
	logic [31:0] chunk_q;
	logic [31:0] loc_q;
	logic [14:0] n_q;
	logic [15:0] i_q;
	logic        pend_s1;
	logic [63:0] offset_q;
	logic [31:0] size_q;
	logic [31:0] dur_q;
	logic [31:0] cnt_q;
	logic        hit_q;
	res_t        res_q;
	logic        out_valid_q;

	logic        accept;
	logic        run_we, chunk_we, size_we, time_we;
	logic [63:0] run_rdata, chunk_rdata, time_rdata;
	logic [31:0] size_rdata;
	logic [RAW-1:0] run_raddr;
	logic [SAW-1:0] size_raddr;
	logic [8:0]  nruns, ntimes;
	logic        loop_go;
	logic [31:0] run_sum;
	logic [31:0] delta;
	logic        sum_issue;
	logic [14:0] sum_idx;
	logic        div_start, div_done;
	logic [31:0] div_quo, div_rem;
	logic [63:0] t_next;
	logic [31:0] time_sum;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	assign run_we   = accept && (in_data.op == OP_LOAD_RUN)
		&& ({18'd0, in_data.slot} < 32'(RUN_DEPTH));
	assign chunk_we = accept && (in_data.op == OP_LOAD_CHUNK)
		&& ({18'd0, in_data.slot} < 32'(CHUNK_DEPTH));
	assign size_we  = accept && (in_data.op == OP_LOAD_SIZE)
		&& ({18'd0, in_data.slot} < 32'(SAMPLE_DEPTH));
	assign time_we  = accept && (in_data.op == OP_LOAD_TIME)
		&& ({18'd0, in_data.slot} < 32'(TIME_DEPTH));

	assign nruns  = ({4'd0, run_entries_q} > 13'(RUN_DEPTH)) ? 9'(RUN_DEPTH) : run_entries_q;
	assign ntimes = ({4'd0, time_entries_q} > 13'(TIME_DEPTH)) ? 9'(TIME_DEPTH)
		: time_entries_q;
	assign loop_go = ({1'b0, run_cursor_q} + 10'd1) < {1'b0, nruns};

	assign run_raddr  = (state_q == S_RUN_A) ? RAW'({1'b0, run_cursor_q} + 10'd1)
		: RAW'(run_cursor_q);
	assign sum_issue  = {1'b0, n_q} >= i_q;
	assign sum_idx    = next_sample_q - i_q[14:0];
	assign size_raddr = (state_q == S_SUM) ? SAW'(sum_idx) : SAW'(next_sample_q);

	assign run_sum  = run_first_q + span_q;
	assign delta    = {17'd0, next_sample_q} - run_first_q;
	assign div_start = (state_q == S_DIV_SET) && (cur_q[63:32] != '0);
	assign t_next   = (next_sample_q == '0) ? 64'd0 : last_time_q + {32'd0, dur_q};
	assign time_sum = time_first_q + cnt_q;

	mstw_ram #(.W(64), .DEPTH(RUN_DEPTH)) u_run_ram (
		.clk(clk), .we(run_we), .waddr(RAW'(in_data.slot)),
		.wdata({in_data.second_value, in_data.first_value[31:0] - 32'd1}),
		.raddr(run_raddr), .rdata(run_rdata)
	);

	mstw_ram #(.W(64), .DEPTH(CHUNK_DEPTH)) u_chunk_ram (
		.clk(clk), .we(chunk_we), .waddr(CAW'(in_data.slot)),
		.wdata(in_data.first_value), .raddr(CAW'(chunk_q)), .rdata(chunk_rdata)
	);

	mstw_ram #(.W(32), .DEPTH(SAMPLE_DEPTH)) u_size_ram (
		.clk(clk), .we(size_we), .waddr(SAW'(in_data.slot)),
		.wdata(in_data.first_value[31:0]), .raddr(size_raddr), .rdata(size_rdata)
	);

	mstw_ram #(.W(64), .DEPTH(TIME_DEPTH)) u_time_ram (
		.clk(clk), .we(time_we), .waddr(TAW'(in_data.slot)),
		.wdata({in_data.second_value, in_data.first_value[31:0]}),
		.raddr(TAW'(time_cursor_q)), .rdata(time_rdata)
	);

	mstw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(delta),
		.divisor(cur_q[63:32]), .done(div_done), .quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_entries_q  <= '0;
			time_entries_q <= '0;
			sample_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RUN_ENTRIES:  run_entries_q  <= cfg_data[8:0];
				REG_TIME_ENTRIES: time_entries_q <= cfg_data[8:0];
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			next_sample_q <= '0;
			run_cursor_q  <= '0;
			run_first_q   <= '0;
			time_cursor_q <= '0;
			time_first_q  <= '0;
			last_time_q   <= '0;
			out_valid_q   <= 1'b0;
			pend_s1       <= 1'b0;
			res_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.op == OP_REQUEST) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (next_sample_q >= sample_count_q) begin
						res_q   <= '{64'd0, 32'd0, 64'd0, ST_PAST_END};
						state_q <= S_OUT;
					end else if (nruns == '0 || run_cursor_q >= nruns) begin
						res_q   <= '{64'd0, 32'd0, 64'd0, ST_NO_RUNS};
						state_q <= S_OUT;
					end else begin
						state_q <= S_RUN_A;
					end
				end
				S_RUN_A: begin
					cur_q   <= run_rdata;
					state_q <= loop_go ? S_RUN_B : S_DIV_SET;
				end
				S_RUN_B: begin
					diff_q  <= run_rdata[31:0] - cur_q[31:0];
					state_q <= S_RUN_MUL;
				end
				S_RUN_MUL: begin
					span_q  <= 32'(diff_q * cur_q[63:32]);
					state_q <= S_RUN_CMP;
				end
				S_RUN_CMP: begin
					if ({17'd0, next_sample_q} < run_sum) begin
						state_q <= S_DIV_SET;
					end else begin
						run_first_q  <= run_sum;
						run_cursor_q <= run_cursor_q + 9'd1;
						state_q      <= S_CHECK;
					end
				end
				S_DIV_SET: begin
					if (cur_q[63:32] == '0) begin
						chunk_q <= cur_q[31:0];
						loc_q   <= '0;
						state_q <= S_OFS;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						chunk_q <= cur_q[31:0] + div_quo;
						loc_q   <= div_rem;
						state_q <= S_OFS;
					end
				end
				S_OFS: begin
					state_q <= S_OFS_D;
				end
				S_OFS_D: begin
					offset_q <= (chunk_q < 32'(CHUNK_DEPTH)) ? chunk_rdata : 64'd0;
					n_q      <= (loc_q < {17'd0, next_sample_q}) ? loc_q[14:0]
						: next_sample_q;
					i_q      <= 16'd1;
					pend_s1  <= 1'b0;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					pend_s1 <= sum_issue && ({17'd0, sum_idx} < 32'(SAMPLE_DEPTH));
					if (sum_issue) begin
						i_q <= i_q + 16'd1;
					end
					if (pend_s1) begin
						offset_q <= offset_q + {32'd0, size_rdata};
					end
					if (!sum_issue && !pend_s1) begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					state_q <= S_SIZE_D;
				end
				S_SIZE_D: begin
					size_q  <= ({17'd0, next_sample_q} < 32'(SAMPLE_DEPTH)) ? size_rdata
						: 32'd0;
					state_q <= S_TIME;
				end
				S_TIME: begin
					if (time_cursor_q < ntimes) begin
						state_q <= S_TIME_D;
					end else begin
						dur_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_TIME_D: begin
					if (time_rdata[31:0] == '0) begin
						time_cursor_q <= time_cursor_q + 9'd1;
						state_q       <= S_TIME;
					end else begin
						dur_q   <= time_rdata[63:32];
						cnt_q   <= time_rdata[31:0];
						hit_q   <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					last_time_q <= t_next;
					if (hit_q && {17'd0, next_sample_q} == time_sum) begin
						time_first_q  <= time_sum;
						time_cursor_q <= time_cursor_q + 9'd1;
					end
					res_q         <= '{offset_q, size_q, t_next, ST_OK};
					next_sample_q <= next_sample_q + 15'd1;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for mp4_sample_table_walker_unit: table loads, sample
// requests and register writes, each result checked against a built-in walker.
// Depends on mstw_pkg and the walker RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mstw_pkg::*;

	localparam int unsigned RUN_D = 256;
	localparam int unsigned CHUNK_D = 4096;
	localparam int unsigned SAMPLE_D = 16384;
	localparam int unsigned TIME_D = 256;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int LIMIT = 20000000;
	localparam int SETTLE = 60;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		bit         is_reg;
		logic [1:0] reg_idx;
		logic [14:0] reg_val;
		req_t       item;
		bit         typed;
		res_t       want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;

	mp4_sample_table_walker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// walker state
	longint unsigned run_tab [RUN_D];
	longint unsigned chunk_tab [CHUNK_D];
	int unsigned size_tab [SAMPLE_D];
	longint unsigned time_tab [TIME_D];
	bit chunk_wr [CHUNK_D];
	bit size_wr [SAMPLE_D];
	int unsigned cur_sample, run_cur, run_base, time_cur, time_base;
	longint unsigned last_dts;
	int unsigned cfg_runs, cfg_times, cfg_count;

	res_t pending_samples [$];
	dir_row_t dir_rows [$];
	int send_idle = 0;
	int recv_stall = 0;
	int errors = 0;
	int n_results = 0;
	int n_bad_status = 0;
	int n_loads = 0;
	int cycles = 0;

	function automatic void walk_sample(input bit commit, output res_t r,
			output int unsigned chunk_rd);
		int unsigned rc, rfs, tc, tfs, nruns, ntimes, a, b, span;
		int unsigned start, spc, delta, chunk, loc, n, idx, dur, cnt;
		longint unsigned offs, t;
		r = '0;
		chunk_rd = CHUNK_D;
		rc = run_cur; rfs = run_base; tc = time_cur; tfs = time_base;
		if (cur_sample >= cfg_count) begin
			r.status = ST_PAST_END;
			return;
		end
		nruns = cfg_runs > RUN_D ? RUN_D : cfg_runs;
		if (nruns == 0 || rc >= nruns) begin
			r.status = ST_NO_RUNS;
			return;
		end
		while (rc + 1 < nruns) begin
			a = run_tab[rc][31:0];
			b = run_tab[rc + 1][31:0];
			span = (b - a) * int'(run_tab[rc][63:32]);
			if (cur_sample < rfs + span)
				break;
			rfs = rfs + span;
			rc++;
		end
		start = run_tab[rc][31:0];
		spc = run_tab[rc][63:32];
		delta = cur_sample - rfs;
		if (spc != 0) begin
			chunk = start + delta / spc;
			loc = delta % spc;
		end else begin
			chunk = start;
			loc = 0;
		end
		chunk_rd = chunk;
		offs = chunk < CHUNK_D ? chunk_tab[chunk] : 64'd0;
		n = loc > cur_sample ? cur_sample : loc;
		for (int unsigned i = 1; i <= n; i++) begin
			idx = cur_sample - i;
			if (idx < SAMPLE_D)
				offs += size_tab[idx];
		end
		ntimes = cfg_times > TIME_D ? TIME_D : cfg_times;
		while (tc < ntimes && time_tab[tc][31:0] == 0)
			tc++;
		dur = tc < ntimes ? time_tab[tc][63:32] : 0;
		t = cur_sample == 0 ? 64'd0 : last_dts + dur;
		if (tc < ntimes) begin
			cnt = time_tab[tc][31:0];
			if (cur_sample == tfs + cnt) begin
				tfs = tfs + cnt;
				tc++;
			end
		end
		r.sample_offset = offs;
		r.sample_size = cur_sample < SAMPLE_D ? size_tab[cur_sample] : 32'd0;
		r.decode_time = t;
		r.status = ST_OK;
		if (commit) begin
			run_cur = rc; run_base = rfs; time_cur = tc; time_base = tfs;
			last_dts = t;
			cur_sample = (cur_sample + 1) & 32'h7FFF;
		end
	endfunction

	function automatic bit apply_item(input req_t q, output res_t r);
		int unsigned ch;
		r = '0;
		case (q.op)
			OP_LOAD_RUN: begin
				if (q.slot < RUN_D)
					run_tab[q.slot] = {q.second_value, q.first_value[31:0] - 32'd1};
			end
			OP_LOAD_CHUNK: begin
				if (q.slot < CHUNK_D) begin
					chunk_tab[q.slot] = q.first_value;
					chunk_wr[q.slot] = 1'b1;
				end
			end
			OP_LOAD_SIZE: begin
				if (q.slot < SAMPLE_D) begin
					size_tab[q.slot] = q.first_value[31:0];
					size_wr[q.slot] = 1'b1;
				end
			end
			OP_LOAD_TIME: begin
				if (q.slot < TIME_D)
					time_tab[q.slot] = {q.second_value, q.first_value[31:0]};
			end
			OP_REQUEST: begin
				walk_sample(1'b1, r, ch);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic req_t make_item(logic [2:0] op, logic [13:0] slot,
			logic [63:0] a, logic [31:0] b);
		req_t q;
		q.op = op; q.slot = slot; q.first_value = a; q.second_value = b;
		return q;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s at result %0d: got %h want %h", field, n_results, got, want);
		errors++;
	endtask

	task automatic send(req_t q, bit typed = 1'b0, res_t want = '0);
		res_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data = q;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (apply_item(q, r))
			pending_samples.push_back(typed ? want : r);
		else
			n_loads++;
	endtask

	// load the chunk entry and the size entry the next request would read, if not yet written
	task automatic send_request(req_t q, bit typed = 1'b0, res_t want = '0);
		res_t r;
		int unsigned ch;
		walk_sample(1'b0, r, ch);
		if (ch < CHUNK_D && !chunk_wr[ch])
			send(make_item(OP_LOAD_CHUNK, 14'(ch), rand64(), $urandom));
		if (cur_sample < cfg_count && cur_sample < SAMPLE_D && !size_wr[cur_sample])
			send(make_item(OP_LOAD_SIZE, 14'(cur_sample), rand64(), $urandom));
		send(q, typed, want);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		drain();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RUN_ENTRIES:  cfg_runs = val[8:0];
			REG_TIME_ENTRIES: cfg_times = val[8:0];
			REG_SAMPLE_COUNT: cfg_count = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_item(logic [2:0] op, logic [13:0] slot, logic [63:0] a,
			logic [31:0] b);
		dir_row_t row;
		row = '{default: '0};
		row.item = make_item(op, slot, a, b);
		dir_rows.push_back(row);
	endtask

	task automatic add_reg(logic [1:0] idx, logic [14:0] val);
		dir_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		dir_rows.push_back(row);
	endtask

	task automatic add_error_request(logic [1:0] st);
		dir_row_t row;
		row = '{default: '0};
		row.item = make_item(OP_REQUEST, '1, '1, '1);
		row.typed = 1'b1;
		row.want.status = st;
		dir_rows.push_back(row);
	endtask

	always @(negedge clk)
		out_ready = $urandom_range(99) >= recv_stall;

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				$display("unexpected result %h", out_data);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (out_data.sample_offset !== want.sample_offset)
					report_mismatch("sample_offset", out_data.sample_offset,
						want.sample_offset);
				if (out_data.sample_size !== want.sample_size)
					report_mismatch("sample_size", out_data.sample_size, want.sample_size);
				if (out_data.decode_time !== want.decode_time)
					report_mismatch("decode_time", out_data.decode_time, want.decode_time);
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
				if (want.status != ST_OK)
					n_bad_status++;
				n_results++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_samples.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned first, pick, cnt;
		int modes_send [4] = '{0, 71, 0, 26};
		int modes_recv [4] = '{0, 0, 71, 26};
		int runs_set [PHASES] = '{256, 511, 0, 256, 1, 300, 256, 256};
		int times_set [PHASES] = '{256, 0, 511, 300, 256, 1, 256, 256};
		req_t q;

		cur_sample = 0; run_cur = 0; run_base = 0; time_cur = 0; time_base = 0;
		last_dts = 0; cfg_runs = 0; cfg_times = 0; cfg_count = 0;
		foreach (chunk_wr[i]) chunk_wr[i] = 1'b0;
		foreach (size_wr[i]) size_wr[i] = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_error_request(ST_PAST_END);
		add_reg(REG_SAMPLE_COUNT, 15'd4);
		add_error_request(ST_NO_RUNS);
		add_item(OP_LOAD_RUN, 14'd0, 64'd1, 32'd2);
		add_item(OP_LOAD_RUN, 14'd1, 64'd2, 32'd0);
		add_item(OP_LOAD_RUN, 14'd300, '1, '1);
		add_item(OP_LOAD_CHUNK, 14'd0, 64'hFFFF_FFFF_FFFF_FFF0, '0);
		add_item(OP_LOAD_CHUNK, 14'd1, 64'd1000, '1);
		add_item(OP_LOAD_CHUNK, 14'h3FFF, '1, '0);
		add_item(OP_LOAD_SIZE, 14'd0, '1, '0);
		add_item(OP_LOAD_SIZE, 14'd1, 64'd5, '0);
		add_item(OP_LOAD_SIZE, 14'd2, 64'd7, '0);
		add_item(OP_LOAD_SIZE, 14'd3, 64'd9, '0);
		add_item(OP_LOAD_SIZE, 14'h3FFF, '1, '1);
		add_item(OP_LOAD_TIME, 14'd0, 64'd0, 32'd99);
		add_item(OP_LOAD_TIME, 14'd1, 64'd2, '1);
		add_item(OP_LOAD_TIME, 14'd2, 64'd5, 32'd3);
		add_item(OP_SPARE_LO, 14'd0, '1, '1);
		add_item(OP_SPARE_HI, '1, '0, '0);
		add_reg(REG_RUN_ENTRIES, 15'd2);
		add_reg(REG_TIME_ENTRIES, 15'd3);
		repeat (4) add_item(OP_REQUEST, '0, '0, '0);
		add_error_request(ST_PAST_END);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else if (dir_rows[i].item.op == OP_REQUEST)
				send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
			else
				send(dir_rows[i].item);
		end

		// well-formed run and time tables for the random part
		first = 1;
		for (int i = 0; i < RUN_D; i++) begin
			first += $urandom_range(1, 3);
			send(make_item(OP_LOAD_RUN, 14'(i), {$urandom, first},
				$urandom_range(15) == 0 ? 32'd0 : $urandom_range(1, 6)));
		end
		for (int i = 0; i < TIME_D; i++)
			send(make_item(OP_LOAD_TIME, 14'(i), {$urandom, 32'($urandom_range(0, 4))},
				$urandom));

		for (int p = 0; p < PHASES; p++) begin
			send_idle = 0;
			recv_stall = 0;
			if (p == 2)
				cnt = 0;
			else if (p == 5)
				cnt = cur_sample;
			else if (p == PHASES - 1)
				cnt = SAMPLE_D;
			else
				cnt = cur_sample + $urandom_range(20, 120);
			write_reg(REG_RUN_ENTRIES, 15'(runs_set[p]));
			write_reg(REG_TIME_ENTRIES, 15'(times_set[p]));
			write_reg(REG_SAMPLE_COUNT, 15'(cnt));
			send_idle = modes_send[p % 4];
			recv_stall = modes_recv[p % 4];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(99);
				q = make_item(OP_REQUEST, 14'($urandom), rand64(), $urandom);
				if (pick < 55) begin
					send_request(q);
				end else begin
					if (pick < 70) begin
						q.op = OP_LOAD_SIZE;
						q.slot = $urandom_range(1) ? 14'($urandom_range(300)) : 14'($urandom);
					end else if (pick < 78)
						q.op = OP_LOAD_CHUNK;
					else if (pick < 84)
						q.op = OP_LOAD_RUN;
					else if (pick < 90)
						q.op = OP_LOAD_TIME;
					else
						q.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
					send(q);
				end
			end
		end
		drain();

		$display("covered %0d results (%0d with error status) and %0d loads or ignored items",
			n_results, n_bad_status, n_loads);
		$display("over %0d register phases with mixed sender and receiver stalls", PHASES);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
sv/mstw_pkg.sv
sv/mstw_ram.sv
sv/mstw_div.sv
sv/mp4_sample_table_walker_unit.sv
tb/sv/testbench.sv
